>>> sv/dheap_pkg.sv
// Shared operation and status codes for the d-ary min-heap queue.
package dheap_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_REM_MIN = 2'd1,
        KIND_REM_POS = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_POS   = 2'd3
    } status_t;

    localparam int IN_VALUE_W  = 32;
    localparam int POSITION_W  = 6;
    localparam int OUT_COUNT_W = 7;
    localparam int ARITY_W     = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 48;

endpackage

>>> sv/dheap_mem.sv
// Heap entry store: one write port, one read port with registered read data.
module dheap_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/dheap_div.sv
// Restoring divider, one quotient bit per cycle, for the parent slot index.
module dheap_div #(
    parameter int NUM_W = 6,
    parameter int DEN_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             take;

    // Shift in the next numerator bit and try the subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        take  = (trial >= {1'b0, den});
    end

    // Iterate over the numerator bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            quo_reg <= (quo_reg << 1) | NUM_W'(take);
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> sv/d_ary_min_heap_queue_unit.sv
// d-ary min-heap priority queue: control sequencer over a one-port-read heap store.
// Errors and clear go straight to the registered result; an insert into an empty heap
// writes its slot first; removals read the removed entry, then the last one unless it was it;
// an upward sift level runs the serial parent divide and reads the parent, a downward one reads each child.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: asynchronous active-low; clears the count, arity to 2 and the output valid;
// store contents are undefined until written.
module d_ary_min_heap_queue_unit #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_ARITY   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dheap_pkg::ARITY_W-1:0]     cfg_wdata,   // arity
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dheap_pkg::S_TDATA_W-1:0]   s_tdata,     // value[31:0], position[37:32]
    input  logic [1:0]                        s_tuser,     // kind[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // removed_value[31:0], status[33:32], count[40:34], is_empty[41], is_full[42]
    output logic [dheap_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dheap_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DW    = $clog2(MAX_ARITY + 1);
    localparam int CHW   = CW + DW;
    localparam int EXT_W = (VALUE_WIDTH > IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_REM, S_RD_LAST, S_DIV, S_RD_PAR,
        S_DN_INIT, S_DN_RD, S_DN_CMP, S_WR_FIN, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [ARITY_W-1:0]      arity_reg;
    logic [DW-1:0]           d_reg;
    logic [AW-1:0]           slot_reg;
    logic [AW-1:0]           child_reg;
    logic [AW-1:0]           best_reg;
    logic [DW-1:0]           k_reg;
    logic [CW-1:0]           count_reg;
    logic [VALUE_WIDTH-1:0]  v_reg;
    logic [VALUE_WIDTH-1:0]  best_val_reg;
    logic [VALUE_WIDTH-1:0]  removed_reg;
    status_t                 status_reg;
    logic                    up_mode_reg;
    logic                    div_start_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic [IN_VALUE_W-1:0]   in_value;
    logic [POSITION_W-1:0]   in_pos;
    kind_t                   in_kind;
    logic [EXT_W-1:0]        in_ext;
    logic [VALUE_WIDTH-1:0]  in_val;
    logic [DW-1:0]           eff_d;
    logic [CHW-1:0]          first;
    logic [EXT_W-1:0]        out_ext;

    logic                    wr_en;
    logic [AW-1:0]           waddr;
    logic [VALUE_WIDTH-1:0]  wdata;
    logic [AW-1:0]           raddr;
    logic [VALUE_WIDTH-1:0]  rdata;
    logic                    div_done;
    logic [AW-1:0]           div_quot;
    logic                    v_lt_rd;
    logic                    rd_lt_best;
    logic                    best_lt_v;

    // Unpack the input transfer
    assign in_value = s_tdata[IN_VALUE_W-1:0];
    assign in_pos   = s_tdata[IN_VALUE_W +: POSITION_W];
    assign in_kind  = kind_t'(s_tuser);
    assign in_ext   = EXT_W'($signed(in_value));
    assign in_val   = in_ext[VALUE_WIDTH-1:0];

    // Clamp the configured arity
    always_comb
    begin
        priority if (arity_reg < ARITY_W'(2))
            eff_d = DW'(2);
        else if (int'(arity_reg) > MAX_ARITY)
            eff_d = DW'(MAX_ARITY);
        else
            eff_d = DW'(arity_reg);
    end

    // Signed compares and the first child of the current slot
    assign v_lt_rd    = $signed(v_reg) < $signed(rdata);
    assign rd_lt_best = $signed(rdata) < $signed(best_val_reg);
    assign best_lt_v  = $signed(best_val_reg) < $signed(v_reg);
    assign first      = CHW'(d_reg) * CHW'(slot_reg) + CHW'(1);

    // Read address per state
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:    raddr = (in_kind == KIND_REM_MIN) ? '0 : AW'(in_pos);
            S_RD_REM:  raddr = AW'(count_reg - CW'(1));
            S_DIV:     raddr = div_quot;
            S_DN_INIT: raddr = AW'(first);
            S_DN_RD:   raddr = child_reg + AW'(1);
            default:   raddr = '0;
        endcase
    end

    // Write port per state
    always_comb
    begin
        wr_en = 1'b0;
        waddr = slot_reg;
        wdata = v_reg;
        unique case (state_reg)
            S_RD_PAR:
            begin
                wr_en = v_lt_rd;
                wdata = rdata;
            end
            S_DN_CMP:
            begin
                wr_en = best_lt_v;
                wdata = best_val_reg;
            end
            S_WR_FIN:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    dheap_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk   (clk),
        .wr_en (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    dheap_div #(
        .NUM_W (AW),
        .DEN_W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (slot_reg - AW'(1)),
        .den   (d_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Build the result word
    assign out_ext = EXT_W'($signed(removed_reg));

    // Sequencer: state, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arity_reg     <= ARITY_W'(2);
            count_reg     <= '0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            up_mode_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_we)
            begin
                arity_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_DONE)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        d_reg       <= eff_d;
                        removed_reg <= '0;
                        status_reg  <= ST_OK;
                        unique case (in_kind)
                            KIND_INSERT:
                            begin
                                if (count_reg == CW'(CAPACITY))
                                begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    slot_reg    <= AW'(count_reg);
                                    v_reg       <= in_val;
                                    count_reg   <= count_reg + CW'(1);
                                    up_mode_reg <= 1'b1;
                                    if (count_reg == '0)
                                    begin
                                        state_reg <= S_WR_FIN;
                                    end
                                    else
                                    begin
                                        div_start_reg <= 1'b1;
                                        state_reg     <= S_DIV;
                                    end
                                end
                            end
                            KIND_REM_MIN, KIND_REM_POS:
                            begin
                                priority if (count_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_DONE;
                                end
                                else if (in_kind == KIND_REM_POS &&
                                         int'(in_pos) >= int'(count_reg))
                                begin
                                    status_reg <= ST_BAD_POS;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    slot_reg  <= (in_kind == KIND_REM_MIN) ? '0 : AW'(in_pos);
                                    state_reg <= S_RD_REM;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD_REM:
                begin
                    removed_reg <= rdata;
                    count_reg   <= count_reg - CW'(1);
                    if (CW'(slot_reg) + CW'(1) == count_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RD_LAST;
                end
                S_RD_LAST:
                begin
                    v_reg       <= rdata;
                    up_mode_reg <= 1'b0;
                    if (slot_reg == '0)
                    begin
                        state_reg <= S_DN_INIT;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        best_reg  <= div_quot;
                        state_reg <= S_RD_PAR;
                    end
                end
                S_RD_PAR:
                begin
                    // Parent index waits in best_reg
                    priority if (v_lt_rd)
                    begin
                        slot_reg    <= best_reg;
                        up_mode_reg <= 1'b1;
                        if (best_reg == '0)
                        begin
                            state_reg <= S_WR_FIN;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                    end
                    else if (up_mode_reg)
                        state_reg <= S_WR_FIN;
                    else
                        state_reg <= S_DN_INIT;
                end
                S_DN_INIT:
                begin
                    if (first >= CHW'(count_reg))
                    begin
                        state_reg <= S_WR_FIN;
                    end
                    else
                    begin
                        child_reg <= AW'(first);
                        k_reg     <= DW'(1);
                        state_reg <= S_DN_RD;
                    end
                end
                S_DN_RD:
                begin
                    if (k_reg == DW'(1) || rd_lt_best)
                    begin
                        best_reg     <= child_reg;
                        best_val_reg <= rdata;
                    end
                    if (k_reg < d_reg && CHW'(child_reg) + CHW'(1) < CHW'(count_reg))
                    begin
                        child_reg <= child_reg + AW'(1);
                        k_reg     <= k_reg + DW'(1);
                    end
                    else
                    begin
                        state_reg <= S_DN_CMP;
                    end
                end
                S_DN_CMP:
                begin
                    if (best_lt_v)
                    begin
                        slot_reg  <= best_reg;
                        state_reg <= S_DN_INIT;
                    end
                    else
                    begin
                        state_reg <= S_WR_FIN;
                    end
                end
                S_WR_FIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'b0,
                                         count_reg == CW'(CAPACITY),
                                         count_reg == '0,
                                         OUT_COUNT_W'(count_reg),
                                         status_reg,
                                         out_ext[IN_VALUE_W-1:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the d-ary min-heap priority queue unit.
`timescale 1ns / 1ps

module tb_top;
    import dheap_pkg::*;

    localparam int CAP = 64;
    localparam int MAX_AR = 8;
    localparam int CYCLE_LIMIT = 2000000;

    // Predicted result of one heap operation
    typedef struct packed {
        logic [31:0] removed;
        status_t     status;
        logic [6:0]  count;
        logic        empty;
        logic        full;
    } heap_result_t;

    // Scoreboard: own copy of the heap, queue of predicted results
    class heap_scoreboard;
        logic signed [31:0] slots [CAP];
        int unsigned        n_entries;
        logic [3:0]         arity_reg;
        heap_result_t       pending [$];
        int                 n_mismatch;

        function new();
            n_entries = 0;
            arity_reg = 4'd2;
            n_mismatch = 0;
        endfunction

        function int unsigned fanout();
            if (arity_reg < 2) return 2;
            if (arity_reg > MAX_AR) return MAX_AR;
            return {28'd0, arity_reg};
        endfunction

        function void sift_up(int unsigned s, int unsigned d);
            logic signed [31:0] v;
            int unsigned p;
            v = slots[s];
            while (s > 0) begin
                p = (s - 1) / d;
                if (!(v < slots[p])) break;
                slots[s] = slots[p];
                s = p;
            end
            slots[s] = v;
        endfunction

        function void sift_down(int unsigned s, int unsigned d);
            logic signed [31:0] v;
            int unsigned first, best, c;
            v = slots[s];
            forever begin
                first = d * s + 1;
                best = first;
                if (first >= n_entries) break;
                for (int unsigned k = 2; k <= d; k++) begin
                    c = d * s + k;
                    if (c >= n_entries) break;
                    if (slots[c] < slots[best]) best = c;
                end
                if (!(slots[best] < v)) break;
                slots[s] = slots[best];
                s = best;
            end
            slots[s] = v;
        endfunction

        // Note an accepted operation and predict its result
        function void note_op(kind_t k, logic signed [31:0] val, logic [5:0] pos);
            heap_result_t r;
            int unsigned d, s;
            d = fanout();
            r.removed = '0;
            r.status = ST_OK;
            if (k == KIND_INSERT) begin
                if (n_entries >= CAP) r.status = ST_FULL;
                else begin
                    slots[n_entries] = val;
                    n_entries++;
                    sift_up(n_entries - 1, d);
                end
            end else if (k == KIND_CLEAR) begin
                n_entries = 0;
            end else begin
                s = (k == KIND_REM_MIN) ? 0 : pos;
                if (n_entries == 0) r.status = ST_EMPTY;
                else if (s >= n_entries) r.status = ST_BAD_POS;
                else begin
                    r.removed = slots[s];
                    n_entries--;
                    if (s < n_entries) begin
                        slots[s] = slots[n_entries];
                        if (s > 0 && slots[s] < slots[(s - 1) / d]) sift_up(s, d);
                        else sift_down(s, d);
                    end
                end
            end
            r.count = n_entries[6:0];
            r.empty = (n_entries == 0);
            r.full = (n_entries == CAP);
            pending.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [47:0] data);
            heap_result_t e;
            logic ok;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", data);
                return;
            end
            e = pending.pop_front();
            ok = data[31:0] == e.removed && data[33:32] == e.status &&
                 data[40:34] == e.count && data[41] == e.empty && data[42] == e.full;
            if (!ok) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("bad result: exp val=%h st=%0d cnt=%0d e=%b f=%b, got %h",
                             e.removed, e.status, e.count, e.empty, e.full, data);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    heap_scoreboard sb = new();
    bit  calm = 1'b0;
    int  cycles = 0;

    always #1 clk = ~clk;

    d_ary_min_heap_queue_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Hold the cycle limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("d_ary_min_heap_queue_unit: mismatch");
            $finish;
        end
    end

    // Accept results with random stall bursts
    initial begin : result_side
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // Send one operation, with an optional idle burst first
    task automatic send_op(kind_t k, logic [31:0] val, logic [5:0] pos);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pos, val};
        s_tuser <= k;
        do @(posedge clk); while (!s_tready);
        sb.note_op(k, val, pos);
    endtask

    // Write arity once all results are back
    task automatic set_arity(logic [3:0] a);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.arity_reg = a;
    endtask

    task automatic random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) send_op(KIND_INSERT, $urandom(), 6'($urandom()));
        else if (r < 70) send_op(KIND_REM_MIN, $urandom(), 6'($urandom()));
        else if (r < 97)
            send_op(KIND_REM_POS, $urandom(),
                    (sb.n_entries > 0 && r < 92) ? 6'($urandom_range(0, sb.n_entries - 1))
                                                 : 6'($urandom()));
        else send_op(KIND_CLEAR, $urandom(), 6'($urandom()));
    endtask

    initial begin : stimulus
        logic [3:0] arities [8];
        arities = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd1, 4'd2};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty removals, extremes, bad position, fill past capacity
        send_op(KIND_REM_MIN, 32'h0, 6'd0);
        send_op(KIND_REM_POS, 32'h0, 6'd5);
        send_op(KIND_INSERT, 32'h7fffffff, 6'd63);
        send_op(KIND_INSERT, 32'h80000000, 6'd0);
        send_op(KIND_INSERT, 32'hffffffff, 6'd0);
        send_op(KIND_INSERT, 32'h0, 6'd0);
        send_op(KIND_REM_POS, 32'h0, 6'd63);
        send_op(KIND_REM_POS, 32'h0, 6'd4);
        send_op(KIND_REM_POS, 32'h0, 6'd1);
        send_op(KIND_REM_MIN, 32'h0, 6'd0);
        send_op(KIND_CLEAR, 32'h0, 6'd0);
        set_arity(4'd8);
        repeat (66) send_op(KIND_INSERT, $urandom(), 6'd0);
        send_op(KIND_REM_POS, 32'h0, 6'd63);
        send_op(KIND_REM_POS, 32'h0, 6'd63);
        send_op(KIND_CLEAR, 32'h0, 6'd0);

        // Random phases across arity settings
        foreach (arities[i]) begin
            set_arity(arities[i]);
            if (i == 7) calm = 1'b1;
            repeat (128) random_op();
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.n_mismatch == 0 && sb.pending.size() == 0)
            $display("d_ary_min_heap_queue_unit: match");
        else
            $display("d_ary_min_heap_queue_unit: mismatch");
        $finish;
    end
endmodule
